// ===== hdl/sida_pkg.sv =====
// shared types and constants for the signed integer to decimal text block
// no dependencies

package sida_pkg;

    localparam int VALUE_W         = 32;
    localparam int DIGIT_W         = 4;
    localparam int DIGITS          = 10;
    localparam int BCD_W           = DIGITS * DIGIT_W;
    localparam int CNT_W           = 4;
    localparam int CHAR_W          = 7;
    localparam int STEPS_PER_STAGE = 8;
    localparam int DABBLE_STAGES   = VALUE_W / STEPS_PER_STAGE;

    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
    localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_BIAS = 4'd3;

    // one word in flight through the shift-and-add-3 conversion
    typedef struct packed {
        logic               neg;
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } dabble_t;

endpackage

// ===== hdl/sida_dabble_stage.sv =====
// one registered slice of the binary to bcd conversion (several shift steps)
// depends on sida_pkg

module sida_dabble_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  sida_pkg::dabble_t in_data,
    output logic              in_ready,
    output logic              out_valid,
    output sida_pkg::dabble_t out_data,
    input  logic              out_ready
);

    logic                                            valid_reg;
    sida_pkg::dabble_t                               data_reg;
    sida_pkg::dabble_t                               data_next;
    logic [sida_pkg::BCD_W+sida_pkg::VALUE_W-1:0]    work;

    always_comb begin
        work = {in_data.bcd, in_data.bin};
        for (int s = 0; s < sida_pkg::STEPS_PER_STAGE; s++) begin
            for (int d = 0; d < sida_pkg::DIGITS; d++) begin
                if (work[sida_pkg::VALUE_W + d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W]
                        >= sida_pkg::DIGIT_FIVE) begin
                    work[sida_pkg::VALUE_W + d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] =
                        work[sida_pkg::VALUE_W + d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W]
                        + sida_pkg::DIGIT_BIAS;
                end
            end
            work = work << 1;
        end
        data_next.neg = in_data.neg;
        data_next.bcd = work[sida_pkg::VALUE_W +: sida_pkg::BCD_W];
        data_next.bin = work[sida_pkg::VALUE_W-1:0];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// signed 32-bit integer to decimal ascii text, one character per output word
// depends on sida_pkg and sida_dabble_stage
//
// usage:
//   s_axis carries one signed number per word in tdata. m_axis returns its
//   decimal text most significant character first: a '-' for a negative
//   number, then the digits without leading zeros (zero gives a single '0').
//   tlast marks the final character of each number.
// path: the first character of a number comes out once its word has passed
//   the input register, four conversion slices of eight shift steps, the
//   digit alignment register and the character serialiser.
// throughput: a number with n characters (1 to 11) holds the output for one
//   word per character; the character serialiser at the output sets the rate.
//   Up to six further numbers queue in the pipeline behind it, one per cycle
//   while the stages ahead have room.
// reset: aresetn low for one clock empties the pipeline and drops any partly
//   sent number; no words are valid afterwards.
// stall: while m_axis_tready is low the current character holds, the stages
//   behind fill up, and s_axis_tready drops once every stage is occupied.

module signed_int_to_decimal_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] char_code, [7] zero
    output logic        m_axis_tlast
);

    localparam int NS = sida_pkg::DABBLE_STAGES;

    // input register with magnitude
    logic              in_valid_reg;
    sida_pkg::dabble_t in_data_reg;
    sida_pkg::dabble_t in_data_next;

    logic              stg_valid [NS+1];
    sida_pkg::dabble_t stg_data  [NS+1];
    logic              stg_ready [NS+1];

    // alignment stage
    logic                             al_valid_reg;
    logic                             al_neg_reg;
    logic [sida_pkg::BCD_W-1:0]       al_bcd_reg;
    logic [sida_pkg::CNT_W-1:0]       al_cnt_reg;
    logic [sida_pkg::BCD_W-1:0]       al_bcd_next;
    logic [sida_pkg::CNT_W-1:0]       al_cnt_next;
    logic                             al_ready;

    // character serialiser
    logic                             busy_reg;
    logic                             minus_reg;
    logic [sida_pkg::BCD_W-1:0]       bcd_reg;
    logic [sida_pkg::CNT_W-1:0]       left_reg;
    logic                             load_ok;
    logic                             out_take;
    logic [sida_pkg::CHAR_W-1:0]      char_code;
    logic                             char_last;

    always_comb begin
        in_data_next.neg = s_axis_tdata[sida_pkg::VALUE_W-1];
        in_data_next.bin = s_axis_tdata[sida_pkg::VALUE_W-1]
                           ? (sida_pkg::VALUE_W'(0) - s_axis_tdata) : s_axis_tdata;
        in_data_next.bcd = '0;
    end

    assign s_axis_tready = !in_valid_reg || stg_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_data_reg <= in_data_next;
        end
    end

    assign stg_valid[0]  = in_valid_reg;
    assign stg_data[0]   = in_data_reg;
    assign stg_ready[NS] = al_ready;

    for (genvar i = 0; i < NS; i++) begin : g_dabble
        sida_dabble_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[i]),
            .in_data   (stg_data[i]),
            .in_ready  (stg_ready[i]),
            .out_valid (stg_valid[i+1]),
            .out_data  (stg_data[i+1]),
            .out_ready (stg_ready[i+1])
        );
    end

    // find the leading digit and move it to the top
    always_comb begin
        al_bcd_next = stg_data[NS].bcd;
        al_cnt_next = sida_pkg::CNT_W'(1);
        for (int d = 1; d < sida_pkg::DIGITS; d++) begin
            if (stg_data[NS].bcd[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] != '0) begin
                al_cnt_next = sida_pkg::CNT_W'(d + 1);
                al_bcd_next = stg_data[NS].bcd
                              << (sida_pkg::DIGIT_W * (sida_pkg::DIGITS - 1 - d));
            end
        end
        if (stg_data[NS].bcd[sida_pkg::BCD_W-1 -: sida_pkg::DIGIT_W] == '0
                && al_cnt_next == sida_pkg::CNT_W'(1)) begin
            al_bcd_next = stg_data[NS].bcd
                          << (sida_pkg::DIGIT_W * (sida_pkg::DIGITS - 1));
        end
    end

    assign out_take = busy_reg && m_axis_tready;
    assign load_ok  = !busy_reg || (m_axis_tready && char_last);
    assign al_ready = !al_valid_reg || load_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            al_valid_reg <= 1'b0;
        end else if (al_ready) begin
            al_valid_reg <= stg_valid[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (al_ready && stg_valid[NS]) begin
            al_neg_reg <= stg_data[NS].neg;
            al_bcd_reg <= al_bcd_next;
            al_cnt_reg <= al_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (load_ok) begin
            busy_reg <= al_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ok && al_valid_reg) begin
            minus_reg <= al_neg_reg;
            bcd_reg   <= al_bcd_reg;
            left_reg  <= al_cnt_reg;
        end else if (out_take) begin
            if (minus_reg) begin
                minus_reg <= 1'b0;
            end else begin
                bcd_reg  <= bcd_reg << sida_pkg::DIGIT_W;
                left_reg <= left_reg - sida_pkg::CNT_W'(1);
            end
        end
    end

    assign char_code = minus_reg ? sida_pkg::CHAR_MINUS
                     : sida_pkg::CHAR_ZERO
                       + sida_pkg::CHAR_W'(bcd_reg[sida_pkg::BCD_W-1 -: sida_pkg::DIGIT_W]);
    assign char_last = !minus_reg && (left_reg == sida_pkg::CNT_W'(1));

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = {1'b0, char_code};
    assign m_axis_tlast  = char_last;

endmodule

// ===== hdl/sida_checker.sv =====
// port-level checks for signed_int_to_decimal_ascii, attached by bind
// depends on sida_pkg for the character codes and on the top level's ports

module sida_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata == {1'b0, sida_pkg::CHAR_MINUS}
            || (m_axis_tdata >= {1'b0, sida_pkg::CHAR_ZERO}
                && m_axis_tdata <= {1'b0, sida_pkg::CHAR_ZERO} + 8'd9))
        else $error("output is neither a minus sign nor a digit");

    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata == {1'b0, sida_pkg::CHAR_MINUS} |-> !m_axis_tlast)
        else $error("minus sign flagged as last character");

    // a digit always follows the sign at once
    a_digit_after_minus: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && m_axis_tdata == {1'b0, sida_pkg::CHAR_MINUS} |=>
            m_axis_tvalid && m_axis_tdata != {1'b0, sida_pkg::CHAR_MINUS})
        else $error("no digit directly after minus sign");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not empty after reset");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb_signed_int_to_decimal_ascii.sv =====
// self-checking testbench for signed_int_to_decimal_ascii: numbers go in on s_axis and
// the decimal text coming out of m_axis is checked character by character
// depends on sida_pkg and the signed_int_to_decimal_ascii rtl

module tb_signed_int_to_decimal_ascii;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD  = 20;
    localparam int          RESET_CYCLES = 9;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          MAX_REPORTS = 10;
    localparam int unsigned RADIX       = 10;
    localparam longint      LIMIT_NS    = 64'd20_000_000;

    typedef struct packed {
        logic [sida_pkg::CHAR_W-1:0] code;
        logic                        last;
    } text_char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [6:0] char_code, [7] zero
    logic        m_axis_tlast;

    // characters still owed by the block, oldest first
    text_char_t  pending_text[$];
    int unsigned mismatches = 0;
    int unsigned burst_left = 0;

    // long receiver hold-off, requested by a test and counted by the receiver
    logic        hold_go = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_len = 0;
    int unsigned hold_left = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_left = 0;

    signed_int_to_decimal_ascii u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // decimal text of a 32-bit two's complement number, sign first
    function automatic void predict_text(input logic [31:0] value);
        logic [31:0]                  mag;
        logic [sida_pkg::DIGIT_W-1:0] digit[sida_pkg::DIGITS];
        int                           n;
        mag = value[31] ? (32'd0 - value) : value;
        n = 0;
        do begin
            digit[n] = sida_pkg::DIGIT_W'(mag % RADIX);
            mag = mag / RADIX;
            n++;
        end while (mag != 0);
        if (value[31])
            pending_text.push_back('{code: sida_pkg::CHAR_MINUS, last: 1'b0});
        for (int i = n - 1; i >= 0; i--)
            pending_text.push_back('{code: sida_pkg::CHAR_ZERO + sida_pkg::CHAR_W'(digit[i]),
                                     last: (i == 0)});
    endfunction

    // random number, mostly with a random count of digits, so short and long text are both common
    function automatic logic [31:0] rand_value();
        longint lo;
        longint hi;
        longint mag;
        int     ndig;
        bit     neg;
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        ndig = $urandom_range(1, sida_pkg::DIGITS);
        neg  = 1'($urandom_range(0, 1));
        lo = 1;
        for (int i = 1; i < ndig; i++) lo = lo * RADIX;
        hi = lo * RADIX - 1;
        if (ndig == 1) lo = 0;
        if (hi > 64'd2147483647) hi = neg ? 64'd2147483648 : 64'd2147483647;
        mag = lo + longint'({$urandom, $urandom}) % (hi - lo + 1);
        if (mag < 0) mag = -mag;
        mag = lo + mag % (hi - lo + 1);
        return neg ? 32'(-mag) : 32'(mag);
    endfunction

    // offer one word and wait for it to be taken; valid stays high between words of a burst
    task automatic send_number(input logic [31:0] value);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge aclk); while (!s_axis_tready);
        predict_text(value);
    endtask

    // stop offering and wait until every owed character has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_text.size() != 0) @(posedge aclk);
    endtask

    task automatic test_extremes();
        logic [31:0] corner[$];
        corner = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                   -32'sd100, 32'd12345, -32'sd98765, 32'd999999999, -32'sd999999999,
                   32'd1000000000, -32'sd1000000000, 32'd2147483647, 32'h80000000,
                   -32'sd2147483647, 32'h55555555, 32'haaaaaaaa, 32'd7, -32'sd5};
        foreach (corner[i]) send_number(corner[i]);
        drain();
    endtask

    task automatic test_random_lengths(input int count);
        repeat (count) send_number(rand_value());
    endtask

    // receiver holds off while words keep coming, so the pipeline fills and stalls s_axis
    task automatic test_output_stall();
        hold_len <= $urandom_range(250, 400);
        hold_go  <= ~hold_go;
        repeat (30) send_number(rand_value());
        drain();
    endtask

    // sender waits for the text of each group before sending the next
    task automatic test_pause_between_groups();
        repeat (4) begin
            repeat ($urandom_range(3, 10)) send_number(rand_value());
            drain();
        end
    endtask

    task automatic test_full_range(input int count);
        repeat (count) send_number($urandom);
    endtask

    // receiver: changes its stall pattern every so often, or holds off when asked
    always @(posedge aclk) begin
        if (hold_go != hold_seen) begin
            hold_seen     <= hold_go;
            hold_left     <= hold_len;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_left <= $urandom_range(20, 200);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 7) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // compare each character that leaves with the oldest owed one
    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_text.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected word tdata=%h tlast=%b", $realtime,
                             m_axis_tdata, m_axis_tlast);
            end else begin
                want = pending_text.pop_front();
                if (m_axis_tdata !== {1'b0, want.code} || m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: expected char %0d last %b, got tdata=%h tlast=%b",
                                 $realtime, want.code, want.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_random_lengths(120);
        test_output_stall();
        test_pause_between_groups();
        test_random_lengths(60);
        test_full_range(60);

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_text.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
